[hdl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared item types, sequencer control structs, hash constants and the
// sigma functions used by the schedule and round units.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    // Eight hash words, index 0 (word a) leftmost.
    typedef logic [0:7][31:0] hash_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        final_word;
    } out_item_t;

    // Request from the round unit to the message schedule.
    typedef struct packed {
        logic step;
        logic expand;
    } sched_req_t;

    // Full control of the message schedule.
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
        logic       expand;
    } sched_ctrl_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] EXPAND_RND = 6'd15;
    localparam logic [5:0] LAST_RND   = 6'd63;
    localparam logic [1:0] LAST_WORD  = 2'd3;

    localparam hash_t HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

[hdl/sha256_in_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 input channel
// Valid/ready channel that carries one message item per transfer.
// ----------------------------------------------------------------------------
interface sha256_in_if import sha256_pkg::*;;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

[hdl/sha256_out_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 output channel
// Valid/ready channel that carries one 64-bit digest word per transfer.
// ----------------------------------------------------------------------------
interface sha256_out_if import sha256_pkg::*;;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

[hdl/sha256_schedule.sv]
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word window that first collects the block bytes and then rolls
// through the expanded schedule, one word per round.
// ----------------------------------------------------------------------------
module sha256_schedule
    import sha256_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    output word_t       w
);

    // Entry 0 is the oldest word of the window.
    word_t win_reg [16];
    word_t w_reg;
    word_t w_next;

    always_comb
    begin
        if (ctrl.expand)
        begin
            w_next = small_sigma1(win_reg[14]) + win_reg[9]
                   + small_sigma0(win_reg[1]) + win_reg[0];
        end
        else
        begin
            w_next = win_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], ctrl.push_byte};
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_next;
            w_reg       <= w_next;
        end
    end

    assign w = w_reg;

endmodule

[hdl/sha256_round.sv]
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle on the working variables, 64 rounds per
// block, with a done pulse once the last round has been applied.
// ----------------------------------------------------------------------------
module sha256_round
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  hash_t      hash_in,
    input  word_t      w_in,
    output sched_req_t sched_req,
    output hash_t      vars,
    output logic       done
);

    hash_t      vars_reg;
    logic [5:0] rnd_reg;
    logic       busy_reg;
    logic       done_reg;
    word_t      t1;
    word_t      t2;
    word_t      ch;
    word_t      maj;

    always_comb
    begin
        ch  = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
            ^ (vars_reg[1] & vars_reg[2]);
        t1  = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + ROUND_K[rnd_reg] + w_in;
        t2  = big_sigma0(vars_reg[0]) + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == LAST_RND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vars_reg <= hash_in;
        end
        else if (busy_reg)
        begin
            vars_reg <= {t1 + t2, vars_reg[0], vars_reg[1], vars_reg[2],
                         vars_reg[3] + t1, vars_reg[4], vars_reg[5], vars_reg[6]};
        end
    end

    // The schedule registers the word for the following round, so it is ready when that round starts.
    assign sched_req.step   = start | busy_reg;
    assign sched_req.expand = busy_reg && (rnd_reg >= EXPAND_RND);
    assign vars             = vars_reg;
    assign done             = done_reg;

endmodule

[hdl/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte stream with SHA-256 and returns the digest as four words.
// ----------------------------------------------------------------------------
// A byte that does not complete a block is taken and the hasher is ready
// for the next byte; a byte that completes a block first passes through
// transfer, load, the rounds and the final add. An end item leads to padding
// and one or two compressions before the four digest transfers. Throughput
// is set by the single round unit: no new bytes are taken while it works.
// Reset is asynchronous and active low; it loads the initial hash values.
// ----------------------------------------------------------------------------
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha256_in_if.sink    msg,
    sha256_out_if.source digest
);

    // The sequencer walks through byte collection, padding, compression and digest output.
    // Padding bytes go through the same window as message bytes, one per
    // cycle, so the schedule always sees exactly 64 bytes per block.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_COMP,
        S_OUT
    } state_t;

    state_t      state_reg;
    hash_t       hash_reg;
    logic [60:0] count_reg;
    logic [5:0]  pos_reg;
    logic        mark_sent_reg;
    logic        len_ok_reg;
    logic        pad_pend_reg;
    logic        final_reg;
    logic [1:0]  idx_reg;

    logic        accept;
    logic        push;
    logic        block_full;
    logic [7:0]  pad_byte;
    logic [7:0]  len_byte;
    logic [63:0] bit_len;
    sched_ctrl_t sched_ctrl;
    sched_req_t  sched_req;
    word_t       sched_w;
    hash_t       round_vars;
    logic        round_done;

    assign msg.ready = (state_reg == S_IDLE);
    assign accept    = msg.valid && msg.ready;

    // The length field is taken big-endian from the bit count, one byte for
    // each of the last eight positions of the final block.
    assign bit_len  = {count_reg, 3'b000};
    assign len_byte = bit_len[{~pos_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        if (!mark_sent_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_ok_reg && (pos_reg >= LEN_POS))
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign push       = (accept && msg.payload.byte_present) || (state_reg == S_PAD);
    assign block_full = push && (pos_reg == BLOCK_LAST);

    always_comb
    begin
        sched_ctrl.push      = push;
        sched_ctrl.push_byte = (state_reg == S_PAD) ? pad_byte : msg.payload.data_byte;
        sched_ctrl.step      = sched_req.step;
        sched_ctrl.expand    = sched_req.expand;
    end

    sha256_schedule u_schedule (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w    (sched_w)
    );

    sha256_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_LOAD),
        .hash_in   (hash_reg),
        .w_in      (sched_w),
        .sched_req (sched_req),
        .vars      (round_vars),
        .done      (round_done)
    );

    // The digest words come straight from the hash registers, which hold
    // still for the whole output phase.
    assign digest.valid               = (state_reg == S_OUT);
    assign digest.payload.digest_word = {hash_reg[{idx_reg, 1'b0}], hash_reg[{idx_reg, 1'b1}]};
    assign digest.payload.word_index  = idx_reg;
    assign digest.payload.final_word  = (idx_reg == LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hash_reg      <= HASH_IV;
            count_reg     <= '0;
            pos_reg       <= '0;
            mark_sent_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            pad_pend_reg  <= 1'b0;
            final_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (push)
            begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (accept && msg.payload.byte_present)
            begin
                count_reg <= count_reg + 61'd1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (block_full)
                        begin
                            state_reg    <= S_LOAD;
                            pad_pend_reg <= msg.payload.end_of_message;
                            final_reg    <= 1'b0;
                        end
                        else if (msg.payload.end_of_message)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end

                S_PAD:
                begin
                    mark_sent_reg <= 1'b1;
                    // The length fits behind the marker only when the marker
                    // lands before the length field; otherwise it waits for
                    // the next block.
                    if (!mark_sent_reg)
                    begin
                        len_ok_reg <= (pos_reg < LEN_POS);
                    end
                    if (block_full)
                    begin
                        state_reg    <= S_LOAD;
                        pad_pend_reg <= 1'b1;
                        final_reg    <= mark_sent_reg && len_ok_reg;
                    end
                end

                S_LOAD:
                begin
                    state_reg <= S_COMP;
                end

                S_COMP:
                begin
                    if (round_done)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_reg[i] <= hash_reg[i] + round_vars[i];
                        end
                        if (final_reg)
                        begin
                            state_reg <= S_OUT;
                            idx_reg   <= '0;
                        end
                        else if (pad_pend_reg)
                        begin
                            state_reg  <= S_PAD;
                            len_ok_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_OUT:
                begin
                    if (digest.ready)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == LAST_WORD)
                        begin
                            // Back to the reset state for the next message.
                            state_reg     <= S_IDLE;
                            hash_reg      <= HASH_IV;
                            count_reg     <= '0;
                            pos_reg       <= '0;
                            mark_sent_reg <= 1'b0;
                            len_ok_reg    <= 1'b0;
                            pad_pend_reg  <= 1'b0;
                            final_reg     <= 1'b0;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
